// File: rtl/ppt_pkg.sv
// shared constants, register codes and the money saturation helper for the position tracker
package ppt_pkg;

    localparam int PRICE_BITS = 32;
    localparam int QTY_BITS   = 24;
    localparam int FRAC_BITS  = 16;

    localparam int SYM_W   = 16;
    localparam int OID_W   = 32;
    localparam int POS_W   = 40;
    localparam int AVG_W   = PRICE_BITS + FRAC_BITS;
    localparam int MONEY_W = 64;
    localparam int CNT_W   = 32;
    localparam int VOL_W   = 48;

    // held magnitude, one bit more than the position to hold |min| and a fresh add
    localparam int MAG_W   = POS_W + 1;
    // notional qty * price with fraction bits
    localparam int NOT_W   = PRICE_BITS + QTY_BITS + FRAC_BITS;
    // dividend bound: held * average cost + notional
    localparam int NUM_W   = AVG_W + POS_W;
    // shared accumulator, wide enough for any product plus a money value
    localparam int ACC_W   = 96;
    localparam int STEP_W  = 7;

    localparam int IN_W    = SYM_W + 2 * OID_W + 2 * PRICE_BITS + QTY_BITS;
    localparam int IN_BYTES = (IN_W + 7) / 8;
    localparam int OUT_W   = POS_W + AVG_W + 4 * MONEY_W + CNT_W + VOL_W;
    localparam int OUT_BYTES = (OUT_W + 7) / 8;

    localparam int APB_AW  = 5;
    localparam int APB_DW  = 64;

    typedef enum logic [1:0] {
        REG_SYMBOL    = 2'd0,
        REG_BUY_ID    = 2'd1,
        REG_SELL_ID   = 2'd2,
        REG_INIT_CASH = 2'd3
    } t_reg_idx;

    function automatic logic [MONEY_W-1:0] f_sat_money(input logic [ACC_W-1:0] v);
        logic hi_zero;
        logic hi_ones;
        hi_zero = (v[ACC_W-1:MONEY_W-1] == '0);
        hi_ones = (v[ACC_W-1:MONEY_W-1] == '1);
        if (hi_zero || hi_ones) begin
            f_sat_money = v[MONEY_W-1:0];
        end else if (v[ACC_W-1]) begin
            f_sat_money = {1'b1, {(MONEY_W-1){1'b0}}};
        end else begin
            f_sat_money = {1'b0, {(MONEY_W-1){1'b1}}};
        end
    endfunction

endpackage

// File: rtl/position_pnl_tracker.sv
// average-cost position and profit tracker for one symbol, with its sequencer and shared unit
//
// One executed trade enters per item; the tracker checks the symbol and our resting buy,
// then sell, quote id (an id register of zero never matches) and, when ours, books the
// trade with average-cost accounting: adds grow the position and reweight the average
// cost, closes book realized profit, a close larger than the position flips it and
// restarts the average at the trade price. Every item returns one result with the state
// after the trade and unrealized and total profit at the mark price. Money and average
// cost carry 16 fraction bits; money values saturate to signed 64 bits, average cost to
// 48 bits, position to 40 bits, counters at all ones. All products are built by one
// shift-add unit, one multiplier bit per cycle; the new average cost goes through a
// restoring divider that retires one quotient bit per cycle. An item that is not ours
// takes one product, a close three products, an add three products and the division.
// The block takes one item at a time; a finished result sits in the output register,
// so the next item is accepted while it waits. Configuration is to be written over the
// register port only while idle; the block itself does not enforce it. A write of
// initial cash also loads the cash balance.
module position_pnl_tracker
    import ppt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // trade in
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // symbol_id, buy_order_id, sell_order_id, trade_price, trade_quantity, mark_price
    input  logic [8*IN_BYTES-1:0]     s_axis_tdata,
    // result out
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // out_position, out_average_cost, out_realized_profit, out_cash,
    // out_unrealized_profit, out_total_profit, out_trade_count, out_volume
    output logic [8*OUT_BYTES-1:0]    m_axis_tdata,
    // trade_applied
    output logic                      m_axis_tuser,
    // register port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_AW-1:0]         paddr,
    input  logic [APB_DW-1:0]         pwdata,
    output logic [APB_DW-1:0]         prdata,
    output logic                      pready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_NOT,      // qty * price
        S_APPLY,    // cash, counters, pick add or close
        S_COST,     // held * average cost
        S_SUM,      // plus notional, new position
        S_DIV,      // total / new held
        S_REAL,     // per-unit profit * closed qty
        S_RADD,     // book realized profit
        S_UPREP,    // set up mark-to-market product
        S_UNREAL,   // |mark - avg| * held
        S_FIN       // wait for output register, load result
    } t_state;

    t_state r_state;

    // configuration
    logic [SYM_W-1:0]    r_own_sym;
    logic [OID_W-1:0]    r_buy_id;
    logic [OID_W-1:0]    r_sell_id;
    logic [MONEY_W-1:0]  r_init_cash;

    // tracker state
    logic [POS_W-1:0]    r_pos;
    logic [AVG_W-1:0]    r_avg;
    logic [MONEY_W-1:0]  r_real;
    logic [MONEY_W-1:0]  r_cash;
    logic [CNT_W-1:0]    r_count;
    logic [VOL_W-1:0]    r_vol;

    // item being worked on
    logic [PRICE_BITS-1:0] r_price;
    logic [QTY_BITS-1:0]   r_qty;
    logic [PRICE_BITS-1:0] r_mark;
    logic                  r_buy;
    logic                  r_applied;

    // shared unit
    logic [ACC_W-1:0]    r_acc;
    logic [AVG_W-1:0]    r_mcand;
    logic [MAG_W-1:0]    r_mplier;
    logic [MAG_W-1:0]    r_rem;
    logic [MAG_W-1:0]    r_nheld;
    logic [NOT_W-1:0]    r_notional;
    logic [STEP_W-1:0]   r_step;
    logic                r_neg;

    // output register
    logic                r_m_valid;
    logic [OUT_W-1:0]    r_m_data;
    logic                r_m_user;

    // field split of the input item
    logic [SYM_W-1:0]      w_sym;
    logic [OID_W-1:0]      w_bid;
    logic [OID_W-1:0]      w_sid;
    logic [PRICE_BITS-1:0] w_in_price;
    logic [QTY_BITS-1:0]   w_in_qty;
    logic [PRICE_BITS-1:0] w_in_mark;
    logic                  w_match_buy;
    logic                  w_match_sell;

    logic                  w_cfg_wr;
    t_reg_idx              w_cfg_idx;

    logic [ACC_W-1:0]    w_mul_sum;
    logic [MAG_W:0]      w_rem_sh;
    logic [MAG_W+1:0]    w_div_diff;
    logic [NUM_W-1:0]    w_quot;
    logic [AVG_W-1:0]    w_quot_sat;

    logic [MAG_W-1:0]    w_pos_ext;
    logic [MAG_W-1:0]    w_held;
    logic [MAG_W-1:0]    w_nheld;
    logic [MAG_W-1:0]    w_qty_ext;
    logic                w_qty_le;
    logic [MAG_W-1:0]    w_close_k;
    logic [MAG_W-1:0]    w_rest;
    logic                w_rest_neg;
    logic [POS_W-1:0]    w_rest_pos;
    logic                w_add_case;
    logic [POS_W-1:0]    w_add_pos;

    logic [AVG_W-1:0]    w_pxf;
    logic [AVG_W:0]      w_per;
    logic [AVG_W-1:0]    w_per_mag;
    logic [AVG_W:0]      w_udiff;
    logic [AVG_W-1:0]    w_udiff_mag;

    logic [NOT_W-1:0]    w_notional;
    logic [ACC_W-1:0]    w_cash_ext;
    logic [ACC_W-1:0]    w_cash_new;
    logic [ACC_W-1:0]    w_real_ext;
    logic [ACC_W-1:0]    w_real_new;
    logic [ACC_W-1:0]    w_unreal;
    logic [VOL_W:0]      w_vol_sum;
    logic                w_out_free;

    localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    assign w_sym      = s_axis_tdata[SYM_W-1:0];
    assign w_bid      = s_axis_tdata[SYM_W+OID_W-1:SYM_W];
    assign w_sid      = s_axis_tdata[SYM_W+2*OID_W-1:SYM_W+OID_W];
    assign w_in_price = s_axis_tdata[SYM_W+2*OID_W+PRICE_BITS-1:SYM_W+2*OID_W];
    assign w_in_qty   = s_axis_tdata[SYM_W+2*OID_W+PRICE_BITS+QTY_BITS-1:
                                     SYM_W+2*OID_W+PRICE_BITS];
    assign w_in_mark  = s_axis_tdata[IN_W-1:SYM_W+2*OID_W+PRICE_BITS+QTY_BITS];

    // buy side wins when both ids match
    assign w_match_buy  = (w_sym == r_own_sym) && (w_bid != '0) && (w_bid == r_buy_id);
    assign w_match_sell = (w_sym == r_own_sym) && (w_sid != '0) && (w_sid == r_sell_id)
                          && !w_match_buy;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(8*OUT_BYTES-OUT_W){1'b0}}, r_m_data};
    assign m_axis_tuser  = r_m_user;
    assign pready        = 1'b1;
    assign w_out_free    = !r_m_valid || m_axis_tready;

    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = t_reg_idx'(paddr[APB_AW-1:3]);

    always_comb begin
        case (t_reg_idx'(paddr[APB_AW-1:3]))
            REG_SYMBOL:    prdata = APB_DW'(r_own_sym);
            REG_BUY_ID:    prdata = APB_DW'(r_buy_id);
            REG_SELL_ID:   prdata = APB_DW'(r_sell_id);
            REG_INIT_CASH: prdata = APB_DW'(r_init_cash);
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        // shift-add step, multiplier msb first
        w_mul_sum  = {r_acc[ACC_W-2:0], 1'b0} +
                     (r_mplier[MAG_W-1] ? ACC_W'(r_mcand) : '0);
        // restoring divide step, dividend shifts out of the accumulator
        w_rem_sh   = {r_rem, r_acc[NUM_W-1]};
        w_div_diff = {1'b0, w_rem_sh} - {2'b00, r_nheld};
        w_quot     = {r_acc[NUM_W-2:0], !w_div_diff[MAG_W+1]};
        w_quot_sat = (w_quot[NUM_W-1:AVG_W] != '0) ? '1 : w_quot[AVG_W-1:0];

        w_pos_ext  = {r_pos[POS_W-1], r_pos};
        w_held     = r_pos[POS_W-1] ? (~w_pos_ext + 1'b1) : w_pos_ext;
        w_qty_ext  = MAG_W'(r_qty);
        w_nheld    = w_held + w_qty_ext;
        w_qty_le   = (w_qty_ext <= w_held);
        w_close_k  = w_qty_le ? w_qty_ext : w_held;
        w_rest     = w_qty_le ? (w_held - w_qty_ext) : (w_qty_ext - w_held);
        // partial close keeps the old side, a flip takes the trade's side
        w_rest_neg = w_qty_le ? r_buy : !r_buy;
        w_rest_pos = w_rest_neg ? POS_W'(~w_rest + 1'b1) : POS_W'(w_rest);
        w_add_case = r_buy ? !r_pos[POS_W-1] : (r_pos[POS_W-1] || (r_pos == '0));

        if (r_buy) begin
            w_add_pos = (r_nheld > MAG_W'(POS_MAX)) ? POS_MAX : POS_W'(r_nheld);
        end else begin
            w_add_pos = (r_nheld > MAG_W'(POS_MAX) + 1'b1) ? POS_MIN
                                                           : POS_W'(~r_nheld + 1'b1);
        end

        w_pxf       = {r_price, {FRAC_BITS{1'b0}}};
        // short covered by a buy gains avg - price, long sold gains price - avg
        w_per       = r_buy ? ({1'b0, r_avg} - {1'b0, w_pxf}) : ({1'b0, w_pxf} - {1'b0, r_avg});
        w_per_mag   = w_per[AVG_W] ? AVG_W'(~w_per + 1'b1) : w_per[AVG_W-1:0];
        w_udiff     = {1'b0, r_mark, {FRAC_BITS{1'b0}}} - {1'b0, r_avg};
        w_udiff_mag = w_udiff[AVG_W] ? AVG_W'(~w_udiff + 1'b1) : w_udiff[AVG_W-1:0];

        w_notional  = {r_acc[PRICE_BITS+QTY_BITS-1:0], {FRAC_BITS{1'b0}}};
        w_cash_ext  = {{(ACC_W-MONEY_W){r_cash[MONEY_W-1]}}, r_cash};
        w_cash_new  = r_buy ? (w_cash_ext - ACC_W'(w_notional))
                            : (w_cash_ext + ACC_W'(w_notional));
        w_real_ext  = {{(ACC_W-MONEY_W){r_real[MONEY_W-1]}}, r_real};
        w_real_new  = r_neg ? (w_real_ext - r_acc) : (w_real_ext + r_acc);
        w_unreal    = r_neg ? (~r_acc + 1'b1) : r_acc;
        w_vol_sum   = {1'b0, r_vol} + (VOL_W+1)'(r_qty);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_own_sym   <= '0;
            r_buy_id    <= '0;
            r_sell_id   <= '0;
            r_init_cash <= '0;
            r_pos       <= '0;
            r_avg       <= '0;
            r_real      <= '0;
            r_cash      <= '0;
            r_count     <= '0;
            r_vol       <= '0;
            r_m_valid   <= 1'b0;
            r_step      <= '0;
        end else begin
            // a new result takes the output register as the old one leaves
            if ((r_state == S_FIN) && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            if (w_cfg_wr) begin
                case (w_cfg_idx)
                    REG_SYMBOL:  r_own_sym <= pwdata[SYM_W-1:0];
                    REG_BUY_ID:  r_buy_id  <= pwdata[OID_W-1:0];
                    REG_SELL_ID: r_sell_id <= pwdata[OID_W-1:0];
                    REG_INIT_CASH: begin
                        r_init_cash <= pwdata[MONEY_W-1:0];
                        r_cash      <= pwdata[MONEY_W-1:0];
                    end
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_price   <= w_in_price;
                        r_qty     <= w_in_qty;
                        r_mark    <= w_in_mark;
                        r_buy     <= w_match_buy;
                        r_applied <= w_match_buy || w_match_sell;
                        r_acc     <= '0;
                        r_step    <= '0;
                        r_mcand   <= AVG_W'(w_in_price);
                        r_mplier  <= MAG_W'(w_in_qty);
                        r_state   <= (w_match_buy || w_match_sell) ? S_NOT : S_UPREP;
                    end
                end

                S_NOT, S_COST, S_REAL, S_UNREAL: begin
                    r_acc    <= w_mul_sum;
                    r_mplier <= {r_mplier[MAG_W-2:0], 1'b0};
                    r_step   <= r_step + 1'b1;
                    if (r_step == STEP_W'(MAG_W - 1)) begin
                        r_step <= '0;
                        case (r_state)
                            S_NOT:   r_state <= S_APPLY;
                            S_COST:  r_state <= S_SUM;
                            S_REAL:  r_state <= S_RADD;
                            default: r_state <= S_FIN;
                        endcase
                    end
                end

                S_APPLY: begin
                    r_notional <= w_notional;
                    r_cash     <= f_sat_money(w_cash_new);
                    if (r_count != '1) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_vol  <= w_vol_sum[VOL_W] ? '1 : w_vol_sum[VOL_W-1:0];
                    r_acc  <= '0;
                    r_step <= '0;
                    if (w_add_case) begin
                        r_nheld  <= w_nheld;
                        r_mcand  <= r_avg;
                        r_mplier <= w_held;
                        r_state  <= S_COST;
                    end else begin
                        // per-unit profit is taken before the average moves
                        r_neg    <= w_per[AVG_W];
                        r_mcand  <= w_per_mag;
                        r_mplier <= w_close_k;
                        r_pos    <= w_rest_pos;
                        if (w_qty_le) begin
                            if (w_rest == '0) begin
                                r_avg <= '0;
                            end
                        end else begin
                            r_avg <= w_pxf;
                        end
                        r_state  <= S_REAL;
                    end
                end

                S_SUM: begin
                    r_acc  <= r_acc + ACC_W'(r_notional);
                    r_pos  <= w_add_pos;
                    r_rem  <= '0;
                    r_step <= '0;
                    if (r_nheld == '0) begin
                        r_avg   <= '0;
                        r_state <= S_UPREP;
                    end else begin
                        r_state <= S_DIV;
                    end
                end

                S_DIV: begin
                    r_acc[NUM_W-1:0] <= w_quot;
                    r_rem  <= w_div_diff[MAG_W+1] ? w_rem_sh[MAG_W-1:0]
                                                  : w_div_diff[MAG_W-1:0];
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(NUM_W - 1)) begin
                        r_avg   <= w_quot_sat;
                        r_state <= S_UPREP;
                    end
                end

                S_RADD: begin
                    r_real  <= f_sat_money(w_real_new);
                    r_state <= S_UPREP;
                end

                S_UPREP: begin
                    // flat position gives a zero multiplier, so zero unrealized profit
                    r_acc    <= '0;
                    r_step   <= '0;
                    r_mcand  <= w_udiff_mag;
                    r_mplier <= w_held;
                    r_neg    <= w_udiff[AVG_W] ^ r_pos[POS_W-1];
                    r_state  <= S_UNREAL;
                end

                S_FIN: begin
                    if (w_out_free) begin
                        r_m_user  <= r_applied;
                        r_m_data  <= {r_vol, r_count, f_sat_money(w_real_new),
                                      f_sat_money(w_unreal), r_cash, r_real, r_avg, r_pos};
                        r_state   <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_nheld))
        else $error("divider remainder not below divisor");

    a_div_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_step < STEP_W'(NUM_W)))
        else $error("divider step count overrun");

    a_flat_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && (r_pos == '0)) |-> (r_avg == '0))
        else $error("flat position with nonzero average cost");
`endif

endmodule
